// ===== rtl/fbrb_pkg.sv =====
// Shared types and constants for the rectangle blitter.
`default_nettype none
package fbrb_pkg;

  localparam logic [2:0] OP_FILL  = 3'd0;
  localparam logic [2:0] OP_OPEN  = 3'd1;
  localparam logic [2:0] OP_PIXEL = 3'd2;
  localparam logic [2:0] OP_COPY  = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_OUTSIDE = 3'd1;
  localparam logic [2:0] ST_BADSIZE = 3'd2;
  localparam logic [2:0] ST_EMPTY   = 3'd3;
  localparam logic [2:0] ST_STRAY   = 3'd4;

  localparam logic [1:0] PS_8      = 2'd0;
  localparam logic [1:0] PS_16     = 2'd1;
  localparam logic [1:0] PS_32     = 2'd2;
  localparam logic [1:0] PS_UNSUPP = 2'd3;

  localparam logic [1:0] REG_PITCH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_PSIZE  = 2'd2;

  typedef enum logic [2:0] {
    K_NOP,
    K_PIX,
    K_FILL,
    K_COPY,
    K_READ
  } kind_t;

  // One queued command for the back end.
  typedef struct packed {
    kind_t       kind;
    logic [8:0]  x;
    logic [8:0]  y;
    logic [8:0]  w;
    logic [8:0]  h;
    logic [8:0]  sx;
    logic [8:0]  sy;
    logic [31:0] value;
    logic [2:0]  status;
    logic        done;
  } cmd_t;

  function automatic logic [31:0] size_mask(input logic [1:0] code);
    logic [31:0] m;
    case (code)
      PS_8:    m = 32'h0000_00FF;
      PS_16:   m = 32'h0000_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/framebuffer_rect_blitter.sv =====
// Top level of the rectangle blitter: ports, configuration, front/queue/back.
// Raw pixels and rejected commands are answered straight from the queue head; fill,
// copy and read answer from the back end's finish state. Raw pixels sustain one
// transaction per cycle while the result side is free, one store write port per
// cycle; fill walks one pixel a cycle, copy reads each pixel and then writes it.
// Reset (rst_n, synchronous) restores registers, then clears every word of the pixel
// store while in_tready stays low.
`default_nettype none
module framebuffer_rect_blitter #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // x_pos[7:0], y_pos[15:8], rect_width[24:16], rect_height[33:25],
  // src_x[41:34], src_y[49:42], pixel_value[81:50], zero pad [87:82]
  input  wire logic [87:0] in_tdata,
  // op[2:0]
  input  wire logic [2:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // read_data[31:0]
  output logic [31:0]      out_tdata,
  // status[2:0]
  output logic [2:0]       out_tuser,
  // raw_done
  output logic             out_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [8:0]  cfg_data
);
  logic [8:0] pitch_r, height_r;
  logic [1:0] psize_r;
  logic [8:0] eff_pitch, eff_height;

  fbrb_pkg::cmd_t fcmd, head;
  logic           accept, can_push, q_valid, pop, clearing;

  assign cfg_ready  = 1'b1;
  assign eff_pitch  = (int'(pitch_r) > MAX_WIDTH) ? 9'(MAX_WIDTH) : pitch_r;
  assign eff_height = (int'(height_r) > MAX_HEIGHT) ? 9'(MAX_HEIGHT) : height_r;

  // Config writes beyond the register list are taken and dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pitch_r  <= 9'd256;
      height_r <= 9'd256;
      psize_r  <= fbrb_pkg::PS_32;
    end else if (cfg_valid) begin
      case (cfg_index)
        fbrb_pkg::REG_PITCH:  pitch_r  <= cfg_data;
        fbrb_pkg::REG_HEIGHT: height_r <= cfg_data;
        fbrb_pkg::REG_PSIZE:  psize_r  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Input is held off during the store clear and when the queue is full.
  assign in_tready = can_push && !clearing;
  assign accept    = in_tvalid && in_tready;

  fbrb_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .op          (in_tuser),
    .x_pos       (in_tdata[7:0]),
    .y_pos       (in_tdata[15:8]),
    .rect_width  (in_tdata[24:16]),
    .rect_height (in_tdata[33:25]),
    .src_x       (in_tdata[41:34]),
    .src_y       (in_tdata[49:42]),
    .pixel_value (in_tdata[81:50]),
    .eff_pitch   (eff_pitch),
    .eff_height  (eff_height),
    .psize       (psize_r),
    .cmd         (fcmd)
  );

  fbrb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_cmd  (fcmd),
    .can_push  (can_push),
    .pop       (pop),
    .head      (head),
    .not_empty (q_valid)
  );

  fbrb_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .eff_pitch  (eff_pitch),
    .psize      (psize_r),
    .q_valid    (q_valid),
    .head       (head),
    .pop        (pop),
    .clearing   (clearing),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (out_tdata),
    .out_status (out_tuser),
    .out_done   (out_tlast)
  );
endmodule
`default_nettype wire

// ===== rtl/fbrb_queue.sv =====
// Two-entry command queue between front and back end.
`default_nettype none
module fbrb_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  fbrb_pkg::cmd_t     push_cmd,
  output logic               can_push,
  input  wire logic          pop,
  output fbrb_pkg::cmd_t     head,
  output logic               not_empty
);
  fbrb_pkg::cmd_t ent_r [2];
  logic           wp_r, rp_r;
  logic [1:0]     cnt_r;

  assign can_push  = (cnt_r != 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign head      = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      if (push && !pop)      cnt_r <= cnt_r + 2'd1;
      else if (!push && pop) cnt_r <= cnt_r - 2'd1;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/fbrb_front.sv =====
// Front end: bounds checks, raw rectangle cursor, command classification.
`default_nettype none
module fbrb_front (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        accept,
  input  wire logic [2:0]  op,
  input  wire logic [7:0]  x_pos,
  input  wire logic [7:0]  y_pos,
  input  wire logic [8:0]  rect_width,
  input  wire logic [8:0]  rect_height,
  input  wire logic [7:0]  src_x,
  input  wire logic [7:0]  src_y,
  input  wire logic [31:0] pixel_value,
  input  wire logic [8:0]  eff_pitch,
  input  wire logic [8:0]  eff_height,
  input  wire logic [1:0]  psize,
  output fbrb_pkg::cmd_t   cmd
);
  logic       active_r, active_nxt;
  logic [8:0] org_x_r, org_x_nxt;
  logic [8:0] rw_r, rw_nxt;
  logic [8:0] cx_r, cx_nxt;
  logic [8:0] cy_r, cy_nxt;
  logic [8:0] end_y_r, end_y_nxt;

  logic       dst_out, src_out, empty, bad;
  logic [2:0] rect_st;
  logic [9:0] cx_inc, cy_inc, row_end;

  always_comb begin
    dst_out = ({2'b0, x_pos} + {1'b0, rect_width}) > {1'b0, eff_pitch} ||
              ({2'b0, y_pos} + {1'b0, rect_height}) > {1'b0, eff_height};
    src_out = ({2'b0, src_x} + {1'b0, rect_width}) > {1'b0, eff_pitch} ||
              ({2'b0, src_y} + {1'b0, rect_height}) > {1'b0, eff_height};
    empty   = (rect_width == 9'd0) || (rect_height == 9'd0);
    bad     = (psize == fbrb_pkg::PS_UNSUPP);
    if (dst_out)    rect_st = fbrb_pkg::ST_OUTSIDE;
    else if (empty) rect_st = fbrb_pkg::ST_EMPTY;
    else if (bad)   rect_st = fbrb_pkg::ST_BADSIZE;
    else            rect_st = fbrb_pkg::ST_OK;
    cx_inc  = {1'b0, cx_r} + 10'd1;
    cy_inc  = {1'b0, cy_r} + 10'd1;
    row_end = {1'b0, org_x_r} + {1'b0, rw_r};
  end

  always_comb begin
    active_nxt = active_r;
    org_x_nxt  = org_x_r;
    rw_nxt     = rw_r;
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    end_y_nxt  = end_y_r;

    cmd.kind   = fbrb_pkg::K_NOP;
    cmd.x      = {1'b0, x_pos};
    cmd.y      = {1'b0, y_pos};
    cmd.w      = rect_width;
    cmd.h      = rect_height;
    cmd.sx     = {1'b0, src_x};
    cmd.sy     = {1'b0, src_y};
    cmd.value  = pixel_value;
    cmd.status = fbrb_pkg::ST_OK;
    cmd.done   = 1'b0;

    case (op)
      fbrb_pkg::OP_FILL: begin
        cmd.status = rect_st;
        if (rect_st == fbrb_pkg::ST_OK) cmd.kind = fbrb_pkg::K_FILL;
      end
      fbrb_pkg::OP_OPEN: begin
        cmd.status = rect_st;
        active_nxt = 1'b0;
        if (rect_st == fbrb_pkg::ST_OK) begin
          active_nxt = 1'b1;
          org_x_nxt  = {1'b0, x_pos};
          rw_nxt     = rect_width;
          cx_nxt     = {1'b0, x_pos};
          cy_nxt     = {1'b0, y_pos};
          end_y_nxt  = 9'({1'b0, y_pos} + rect_height);
        end
      end
      fbrb_pkg::OP_PIXEL: begin
        if (!active_r) begin
          cmd.status = fbrb_pkg::ST_STRAY;
        end else begin
          cmd.x = cx_r;
          cmd.y = cy_r;
          if (bad) cmd.status = fbrb_pkg::ST_BADSIZE;
          else     cmd.kind   = fbrb_pkg::K_PIX;
          cx_nxt = cx_inc[8:0];
          if (cx_inc >= row_end) begin
            cx_nxt = org_x_r;
            cy_nxt = cy_inc[8:0];
            if (cy_inc >= {1'b0, end_y_r}) begin
              active_nxt = 1'b0;
              cmd.done   = 1'b1;
            end
          end
        end
      end
      fbrb_pkg::OP_COPY: begin
        cmd.status = (!dst_out && src_out) ? fbrb_pkg::ST_OUTSIDE : rect_st;
        if (!dst_out && !src_out && rect_st == fbrb_pkg::ST_OK) cmd.kind = fbrb_pkg::K_COPY;
      end
      fbrb_pkg::OP_READ: begin
        if ({1'b0, x_pos} >= eff_pitch || {1'b0, y_pos} >= eff_height)
          cmd.status = fbrb_pkg::ST_OUTSIDE;
        else if (bad) cmd.status = fbrb_pkg::ST_BADSIZE;
        else          cmd.kind   = fbrb_pkg::K_READ;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      org_x_r  <= 9'd0;
      rw_r     <= 9'd0;
      cx_r     <= 9'd0;
      cy_r     <= 9'd0;
      end_y_r  <= 9'd0;
    end else if (accept) begin
      active_r <= active_nxt;
      org_x_r  <= org_x_nxt;
      rw_r     <= rw_nxt;
      cx_r     <= cx_nxt;
      cy_r     <= cy_nxt;
      end_y_r  <= end_y_nxt;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/fbrb_back.sv =====
// Back end: pixel store, rectangle walker, result register.
`default_nettype none
module fbrb_back #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [8:0]  eff_pitch,
  input  wire logic [1:0]  psize,
  input  wire logic        q_valid,
  input  fbrb_pkg::cmd_t   head,
  output logic             pop,
  output logic             clearing,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_data,
  output logic [2:0]       out_status,
  output logic             out_done
);
  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW     = $clog2(DEPTH);
  localparam int CALC_W = (AW > 19) ? AW : 19;

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_FILL, S_CRD, S_CWR, S_RD, S_FIN} st_t;

  logic [31:0] mem [DEPTH];
  logic [31:0] rdata_r;

  st_t            st_r;
  fbrb_pkg::cmd_t cmd_r;
  logic [8:0]     r_r, c_r;
  logic           fwd_r, use_rd_r;
  logic [AW-1:0]  clr_r;
  logic           ov_r;
  logic [31:0]    od_r;
  logic [2:0]     os_r;
  logic           odn_r;

  logic              out_free, last_c, last_r, we, ov_set;
  logic [8:0]        rr, cc;
  logic [CALC_W-1:0] wcalc, rcalc, dcalc, scalc;
  logic [31:0]       wdata, mask;

  function automatic logic [CALC_W-1:0] lin(input logic [8:0] row, input logic [8:0] col,
                                            input logic [8:0] p);
    return CALC_W'(row) * CALC_W'(p) + CALC_W'(col);
  endfunction

  assign mask       = fbrb_pkg::size_mask(psize);
  assign out_free   = !ov_r || out_ready;
  assign pop        = (st_r == S_IDLE) && q_valid && out_free;
  assign clearing   = (st_r == S_CLEAR);
  assign out_valid  = ov_r;
  assign out_data   = od_r;
  assign out_status = os_r;
  assign out_done   = odn_r;

  // A result is loaded straight from the queue head, or at the end of a walk.
  assign ov_set = (pop && !(head.kind inside {fbrb_pkg::K_FILL, fbrb_pkg::K_COPY,
                                               fbrb_pkg::K_READ})) ||
                  ((st_r == S_FIN) && out_free);

  always_comb begin
    rr     = fwd_r ? r_r : 9'(cmd_r.h - 9'd1 - r_r);
    cc     = fwd_r ? c_r : 9'(cmd_r.w - 9'd1 - c_r);
    last_c = (c_r == 9'(cmd_r.w - 9'd1));
    last_r = (r_r == 9'(cmd_r.h - 9'd1));
    dcalc  = lin(head.y, head.x, eff_pitch);
    scalc  = lin(head.sy, head.sx, eff_pitch);
    we     = 1'b0;
    wdata  = 32'd0;
    wcalc  = CALC_W'(clr_r);
    rcalc  = lin(cmd_r.y, cmd_r.x, eff_pitch);
    case (st_r)
      S_CLEAR: we = 1'b1;
      S_IDLE: begin
        wcalc = dcalc;
        wdata = head.value & mask;
        we    = pop && (head.kind == fbrb_pkg::K_PIX) && (dcalc < CALC_W'(DEPTH));
      end
      S_FILL: begin
        wcalc = lin(9'(cmd_r.y + r_r), 9'(cmd_r.x + c_r), eff_pitch);
        wdata = cmd_r.value & mask;
        we    = wcalc < CALC_W'(DEPTH);
      end
      S_CRD: rcalc = lin(9'(cmd_r.sy + rr), 9'(cmd_r.sx + cc), eff_pitch);
      S_CWR: begin
        wcalc = lin(9'(cmd_r.y + rr), 9'(cmd_r.x + cc), eff_pitch);
        wdata = rdata_r & mask;
        we    = wcalc < CALC_W'(DEPTH);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[wcalc[AW-1:0]] <= wdata;
    rdata_r <= (rcalc < CALC_W'(DEPTH)) ? mem[rcalc[AW-1:0]] : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_CLEAR;
      clr_r    <= '0;
      ov_r     <= 1'b0;
      r_r      <= 9'd0;
      c_r      <= 9'd0;
      fwd_r    <= 1'b1;
      use_rd_r <= 1'b0;
    end else begin
      if (ov_set)         ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
      case (st_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == AW'(DEPTH - 1)) st_r <= S_IDLE;
        end
        S_IDLE: begin
          if (pop) begin
            cmd_r    <= head;
            r_r      <= 9'd0;
            c_r      <= 9'd0;
            fwd_r    <= dcalc <= scalc;
            use_rd_r <= 1'b0;
            case (head.kind)
              fbrb_pkg::K_FILL: st_r <= S_FILL;
              fbrb_pkg::K_COPY: st_r <= S_CRD;
              fbrb_pkg::K_READ: st_r <= S_RD;
              default: begin
                od_r  <= 32'd0;
                os_r  <= head.status;
                odn_r <= head.done;
              end
            endcase
          end
        end
        S_FILL, S_CWR: begin
          if (last_c) begin
            c_r <= 9'd0;
            if (last_r) st_r <= S_FIN;
            else begin
              r_r  <= r_r + 9'd1;
              st_r <= (st_r == S_CWR) ? S_CRD : S_FILL;
            end
          end else begin
            c_r  <= c_r + 9'd1;
            st_r <= (st_r == S_CWR) ? S_CRD : S_FILL;
          end
        end
        S_CRD: st_r <= S_CWR;
        S_RD: begin
          use_rd_r <= 1'b1;
          st_r     <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            od_r  <= use_rd_r ? (rdata_r & mask) : 32'd0;
            os_r  <= cmd_r.status;
            odn_r <= cmd_r.done;
            st_r  <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== test/tb_framebuffer_rect_blitter.sv =====
// Self-checking testbench for the rectangle blitter: directed table, then random phases.
module tb_framebuffer_rect_blitter;

  // Op codes 5 to 7 carry no command; the block answers them with a plain OK.
  localparam logic [2:0] OP_SPARE_LO  = 3'd5;
  localparam logic [2:0] OP_SPARE_MID = 3'd6;
  localparam logic [2:0] OP_SPARE_HI  = 3'd7;
  localparam int STORE_WORDS = 65536;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int N_PHASES    = 7;

  // One result transaction: read_data, status, raw_done.
  typedef struct packed {
    logic [31:0] data;
    logic [2:0]  status;
    logic        done;
  } blit_res_t;

  // One row of the directed table. A row with typed set carries its own answer.
  typedef struct {
    logic [2:0]  op;
    int          x, y, w, h, sx, sy;
    logic [31:0] pv;
    bit          typed;
    blit_res_t   res;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [87:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [8:0]  cfg_data;

  framebuffer_rect_blitter dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow of the block: pixel store, registers and the open raw rectangle.
  logic [31:0] shadow_store [0:STORE_WORDS-1];
  logic [8:0]  sh_pitch;
  logic [8:0]  sh_height;
  logic [1:0]  sh_psize;
  bit          raw_open;
  int          raw_x0, raw_w, raw_cx, raw_cy, raw_y_end;

  blit_res_t pending_q[$];
  int        mismatches;
  int        sent_items;
  int        results_seen;
  int        cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Runaway guard.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int frame_w();
    return (sh_pitch > 9'd256) ? 256 : int'(sh_pitch);
  endfunction

  function automatic int frame_h();
    return (sh_height > 9'd256) ? 256 : int'(sh_height);
  endfunction

  function automatic logic [31:0] pix_mask();
    case (sh_psize)
      fbrb_pkg::PS_8:  return 32'h0000_00FF;
      fbrb_pkg::PS_16: return 32'h0000_FFFF;
      default:         return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic void store_pixel(int row, int col, logic [31:0] v);
    int a;
    a = row * frame_w() + col;
    if (a < STORE_WORDS) shadow_store[a] = v & pix_mask();
  endfunction

  function automatic logic [31:0] load_pixel(int row, int col);
    int a;
    a = row * frame_w() + col;
    return (a < STORE_WORDS) ? shadow_store[a] : 32'd0;
  endfunction

  // Bounds first, then emptiness, then pixel size.
  function automatic logic [2:0] rect_status(int x, int y, int w, int h);
    if (x + w > frame_w() || y + h > frame_h()) return fbrb_pkg::ST_OUTSIDE;
    if (w == 0 || h == 0) return fbrb_pkg::ST_EMPTY;
    if (sh_psize == fbrb_pkg::PS_UNSUPP) return fbrb_pkg::ST_BADSIZE;
    return fbrb_pkg::ST_OK;
  endfunction

  // Applies one command to the shadow and returns the answer the block owes.
  function automatic blit_res_t blit_predict(logic [2:0] op, int x, int y, int w, int h,
                                             int sx, int sy, logic [31:0] pv);
    blit_res_t r;
    int p, rr, cc;
    bit fwd;
    r = '0;
    case (op)
      fbrb_pkg::OP_FILL: begin
        r.status = rect_status(x, y, w, h);
        if (r.status == fbrb_pkg::ST_OK)
          for (int i = 0; i < h; i++)
            for (int j = 0; j < w; j++) store_pixel(y + i, x + j, pv);
      end
      fbrb_pkg::OP_OPEN: begin
        raw_open = 1'b0;
        r.status = rect_status(x, y, w, h);
        if (r.status == fbrb_pkg::ST_OK) begin
          raw_open = 1'b1;
          raw_x0 = x; raw_w = w; raw_cx = x; raw_cy = y; raw_y_end = y + h;
        end
      end
      fbrb_pkg::OP_PIXEL: begin
        if (!raw_open) r.status = fbrb_pkg::ST_STRAY;
        else begin
          if (sh_psize == fbrb_pkg::PS_UNSUPP) r.status = fbrb_pkg::ST_BADSIZE;
          else store_pixel(raw_cy, raw_cx, pv);
          // cursor moves even when the write was refused
          raw_cx++;
          if (raw_cx >= raw_x0 + raw_w) begin
            raw_cx = raw_x0;
            raw_cy++;
            if (raw_cy >= raw_y_end) begin
              raw_open = 1'b0;
              r.done = 1'b1;
            end
          end
        end
      end
      fbrb_pkg::OP_COPY: begin
        r.status = rect_status(x, y, w, h);
        if (r.status != fbrb_pkg::ST_OUTSIDE && (sx + w > frame_w() || sy + h > frame_h()))
          r.status = fbrb_pkg::ST_OUTSIDE;
        if (r.status == fbrb_pkg::ST_OK) begin
          // walk direction keeps overlapping copies reading old pixels
          p = frame_w();
          fwd = (y * p + x) <= (sy * p + sx);
          for (int i = 0; i < h; i++) begin
            rr = fwd ? i : h - 1 - i;
            for (int j = 0; j < w; j++) begin
              cc = fwd ? j : w - 1 - j;
              store_pixel(y + rr, x + cc, load_pixel(sy + rr, sx + cc));
            end
          end
        end
      end
      fbrb_pkg::OP_READ: begin
        if (x >= frame_w() || y >= frame_h()) r.status = fbrb_pkg::ST_OUTSIDE;
        else if (sh_psize == fbrb_pkg::PS_UNSUPP) r.status = fbrb_pkg::ST_BADSIZE;
        else r.data = load_pixel(y, x) & pix_mask();
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  // Offers one command, waits for its transaction, queues the expected answer.
  task automatic send_cmd(logic [2:0] op, int x, int y, int w, int h, int sx, int sy,
                          logic [31:0] pv, bit typed, blit_res_t typed_res);
    int gap;
    blit_res_t r;
    gap = (sent_items % 160 < 40) ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {6'd0, pv, sy[7:0], sx[7:0], h[8:0], w[8:0], y[7:0], x[7:0]};
    do @(posedge clk); while (!in_tready);
    r = blit_predict(op, x, y, w, h, sx, sy, pv);
    pending_q.push_back(typed ? typed_res : r);
    sent_items++;
  endtask

  task automatic send_pred(logic [2:0] op, int x, int y, int w, int h, int sx, int sy,
                           logic [31:0] pv);
    send_cmd(op, x, y, w, h, sx, sy, pv, 1'b0, '0);
  endtask

  // Drains all answers; rejected commands may still be settling after the last one.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_q.size() != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [8:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      fbrb_pkg::REG_PITCH:  sh_pitch  = val;
      fbrb_pkg::REG_HEIGHT: sh_height = val;
      fbrb_pkg::REG_PSIZE:  sh_psize  = val[1:0];
      default: ;
    endcase
  endtask

  // Corner and size mostly inside the current frame, at most maxd on a side.
  task automatic pick_rect(int maxd, output int x, output int y, output int w, output int h);
    int fw, fh;
    fw = frame_w();
    fh = frame_h();
    if (fw == 0 || fh == 0) begin
      x = $urandom_range(0, 255); y = $urandom_range(0, 255);
      w = $urandom_range(0, 4);   h = $urandom_range(0, 4);
    end else begin
      x = $urandom_range(0, fw - 1);
      y = $urandom_range(0, fh - 1);
      w = $urandom_range(0, (fw - x < maxd) ? fw - x : maxd);
      h = $urandom_range(0, (fh - y < maxd) ? fh - y : maxd);
    end
  endtask

  task automatic run_random(int n_items);
    int done_cnt, sel, x, y, w, h, sx, sy, npix;
    done_cnt = 0;
    while (done_cnt < n_items) begin
      sel = $urandom_range(0, 99);
      if (sel < 35) begin
        // well-formed raw rectangle, now and then interleaved or cut short
        pick_rect(4, x, y, w, h);
        if (w == 0) w = 1;
        if (h == 0) h = 1;
        send_pred(fbrb_pkg::OP_OPEN, x, y, w, h, $urandom_range(0, 255),
                  $urandom_range(0, 255), $urandom());
        done_cnt++;
        npix = w * h;
        for (int k = 0; k < npix; k++) begin
          if ($urandom_range(0, 99) < 10) begin
            send_pred(($urandom_range(0, 1) != 0) ? fbrb_pkg::OP_READ : fbrb_pkg::OP_FILL,
                      $urandom_range(0, 255), $urandom_range(0, 255),
                      $urandom_range(0, 3), $urandom_range(0, 3), 0, 0, $urandom());
            done_cnt++;
          end
          if ($urandom_range(0, 99) < 3) break;
          send_pred(fbrb_pkg::OP_PIXEL, $urandom_range(0, 255), $urandom_range(0, 255),
                    $urandom_range(0, 511), $urandom_range(0, 511), $urandom_range(0, 255),
                    $urandom_range(0, 255), $urandom());
          done_cnt++;
        end
      end else if (sel < 55) begin
        pick_rect(8, x, y, w, h);
        send_pred(fbrb_pkg::OP_FILL, x, y, w, h, $urandom_range(0, 255),
                  $urandom_range(0, 255), $urandom());
        done_cnt++;
      end else if (sel < 70) begin
        pick_rect(6, x, y, w, h);
        sx = (frame_w() > w) ? $urandom_range(0, frame_w() - w) : 0;
        sy = (frame_h() > h) ? $urandom_range(0, frame_h() - h) : 0;
        // near neighbors give overlapping copies in both directions
        if ($urandom_range(0, 1) != 0 && frame_w() > 0) begin
          sx = x + $urandom_range(0, 2) - 1;
          sy = y + $urandom_range(0, 2) - 1;
          if (sx < 0) sx = 0;
          if (sy < 0) sy = 0;
        end
        send_pred(fbrb_pkg::OP_COPY, x, y, w, h, sx, sy, $urandom());
        done_cnt++;
      end else if (sel < 85) begin
        x = $urandom_range(0, (frame_w() < 256) ? frame_w() : 255);
        y = $urandom_range(0, (frame_h() < 256) ? frame_h() : 255);
        send_pred(fbrb_pkg::OP_READ, x, y, $urandom_range(0, 511), $urandom_range(0, 511),
                  $urandom_range(0, 255), $urandom_range(0, 255), $urandom());
        done_cnt++;
      end else if (sel < 88) begin
        send_pred(3'($urandom_range(5, 7)), $urandom_range(0, 255), $urandom_range(0, 255),
                  $urandom_range(0, 511), $urandom_range(0, 511), $urandom_range(0, 255),
                  $urandom_range(0, 255), $urandom());
        done_cnt++;
      end else if (sel < 91) begin
        send_pred(fbrb_pkg::OP_PIXEL, 0, 0, 0, 0, 0, 0, $urandom());
        done_cnt++;
      end else if (sel < 96) begin
        // long thin strips reach the top size bits without long walks
        x = $urandom_range(0, 255);
        y = $urandom_range(0, 255);
        if ($urandom_range(0, 1) != 0) begin
          w = $urandom_range(0, 256); h = $urandom_range(0, 3);
        end else begin
          w = $urandom_range(0, 3);   h = $urandom_range(0, 256);
        end
        send_pred(3'($urandom_range(0, 4)), x, y, w, h, $urandom_range(0, 255),
                  $urandom_range(0, 255), $urandom());
        done_cnt++;
      end else begin
        // noise: every field free, sizes large so that most fall outside the frame
        send_pred(3'($urandom_range(0, 7)), $urandom_range(0, 255), $urandom_range(0, 255),
                  $urandom_range(200, 511), $urandom_range(200, 511),
                  $urandom_range(0, 255), $urandom_range(0, 255), $urandom());
        done_cnt++;
      end
    end
  endtask

  // Result side: random ready, one long hold-off, field compare against the oldest entry.
  int rx_wait;
  always @(posedge clk) begin
    blit_res_t got, want;
    int n;
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_wait    <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = '{data: out_tdata, status: out_tuser, done: out_tlast};
        if (pending_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: data=%h status=%0d done=%0d",
                     got.data, got.status, got.done);
        end else begin
          want = pending_q.pop_front();
          if (got.data !== want.data || got.status !== want.status ||
              got.done !== want.done) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: expected data=%h status=%0d done=%0d, %s%h %s%0d %s%0d",
                       results_seen, want.data, want.status, want.done,
                       "got data=", got.data, "status=", got.status,
                       "done=", got.done);
          end
        end
        results_seen++;
      end
      if (rx_wait > 0) begin
        rx_wait    <= rx_wait - 1;
        out_tready <= 1'b0;
      end else if (out_tvalid && out_tready) begin
        if (results_seen == 300) n = 500;           // back the block up into its input
        else if (results_seen % 128 < 32) n = 0;    // full-rate stretch
        else n = $urandom_range(0, 13);
        if (n == 0) out_tready <= 1'b1;
        else begin
          out_tready <= 1'b0;
          rx_wait    <= n - 1;
        end
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  dir_row_t dir_rows[$];
  int ph_pitch  [N_PHASES] = '{16, 511, 1, 37, 0, 64, 256};
  int ph_height [N_PHASES] = '{16, 300, 1, 20, 0, 48, 256};
  int ph_psize  [N_PHASES] = '{0, 1, 2, 3, 1, 2, 0};

  initial begin
    blit_res_t ok0;
    ok0 = '0;
    for (int i = 0; i < STORE_WORDS; i++) shadow_store[i] = 32'd0;
    sh_pitch = 9'd256; sh_height = 9'd256; sh_psize = fbrb_pkg::PS_32;
    raw_open = 1'b0;
    raw_x0 = 0; raw_w = 0; raw_cx = 0; raw_cy = 0; raw_y_end = 0;
    mismatches = 0; sent_items = 0; results_seen = 0; cycles = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0; in_tdata = '0; in_tuser = '0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;

    // op, x, y, w, h, sx, sy, value, typed, answer
    dir_rows = '{
      '{fbrb_pkg::OP_READ,  0,   0,   0,   0,   0, 0, 32'h0,         1, ok0},
      '{fbrb_pkg::OP_READ,  255, 255, 0,   0,   0, 0, 32'h0,         1, ok0},
      '{fbrb_pkg::OP_FILL,  0,   0,   0,   0,   0, 0, 32'h1234,      1,
        '{0, fbrb_pkg::ST_EMPTY, 0}},
      '{fbrb_pkg::OP_FILL,  255, 0,   2,   1,   0, 0, 32'h1234,      1,
        '{0, fbrb_pkg::ST_OUTSIDE, 0}},
      '{fbrb_pkg::OP_FILL,  0,   0,   256, 1,   0, 0, 32'hFFFF_FFFF, 0, ok0},
      '{fbrb_pkg::OP_READ,  255, 0,   0,   0,   0, 0, 32'h0,         1,
        '{32'hFFFF_FFFF, fbrb_pkg::ST_OK, 0}},
      '{fbrb_pkg::OP_PIXEL, 0,   0,   0,   0,   0, 0, 32'h55,        1,
        '{0, fbrb_pkg::ST_STRAY, 0}},
      '{fbrb_pkg::OP_FILL,  0,   255, 1,   1,   0, 0, 32'hA5A5_5A5A, 0, ok0},
      '{fbrb_pkg::OP_FILL,  0,   0,   1,   256, 0, 0, 32'h8000_0001, 0, ok0},
      '{fbrb_pkg::OP_OPEN,  10,  10,  2,   2,   0, 0, 32'h0,         0, ok0},
      '{fbrb_pkg::OP_PIXEL, 0,   0,   0,   0,   0, 0, 32'h1111_1111, 0, ok0},
      '{fbrb_pkg::OP_READ,  10,  10,  0,   0,   0, 0, 32'h0,         0, ok0},
      '{fbrb_pkg::OP_PIXEL, 0,   0,   0,   0,   0, 0, 32'h2222_2222, 0, ok0},
      '{fbrb_pkg::OP_PIXEL, 0,   0,   0,   0,   0, 0, 32'h3333_3333, 0, ok0},
      '{fbrb_pkg::OP_PIXEL, 0,   0,   0,   0,   0, 0, 32'h4444_4444, 0, ok0},
      '{fbrb_pkg::OP_COPY,  100, 100, 3,   3,   9, 9, 32'h0,         0, ok0},
      '{fbrb_pkg::OP_COPY,  1,   0,   4,   2,   0, 0, 32'h0,         0, ok0},
      '{fbrb_pkg::OP_COPY,  0,   0,   4,   2,   1, 0, 32'h0,         0, ok0},
      '{fbrb_pkg::OP_COPY,  0,   0,   2,   1, 255, 0, 32'h0,         1,
        '{0, fbrb_pkg::ST_OUTSIDE, 0}},
      '{fbrb_pkg::OP_READ,  101, 101, 0,   0,   0, 0, 32'h0,         0, ok0},
      '{OP_SPARE_LO,  7, 7, 7,   7,   7, 7, 32'hDEAD_BEEF, 1, ok0},
      '{OP_SPARE_MID, 0, 0, 0,   0,   0, 0, 32'h0,         1, ok0},
      '{OP_SPARE_HI,  0, 0, 0,   0,   0, 0, 32'h0,         1, ok0},
      '{fbrb_pkg::OP_OPEN,  0,   0,   4,   4,   0, 0, 32'h0,         0, ok0},
      '{fbrb_pkg::OP_OPEN,  0,   0,   0,   4,   0, 0, 32'h0,         1,
        '{0, fbrb_pkg::ST_EMPTY, 0}},
      '{fbrb_pkg::OP_PIXEL, 0,   0,   0,   0,   0, 0, 32'h9,         1,
        '{0, fbrb_pkg::ST_STRAY, 0}}
    };

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      send_cmd(dir_rows[i].op, dir_rows[i].x, dir_rows[i].y, dir_rows[i].w, dir_rows[i].h,
               dir_rows[i].sx, dir_rows[i].sy, dir_rows[i].pv, dir_rows[i].typed,
               dir_rows[i].res);

    // Each phase starts idle, rewrites every register, then runs random traffic.
    // An open raw rectangle may carry over into the next phase on purpose.
    for (int p = 0; p < N_PHASES; p++) begin
      wait_idle();
      write_reg(fbrb_pkg::REG_PITCH, 9'(ph_pitch[p]));
      write_reg(fbrb_pkg::REG_HEIGHT, 9'(ph_height[p]));
      write_reg(fbrb_pkg::REG_PSIZE, 9'(ph_psize[p]));
      run_random(200);
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

// ===== framebuffer_rect_blitter.f =====
rtl/fbrb_pkg.sv
rtl/fbrb_queue.sv
rtl/fbrb_front.sv
rtl/fbrb_back.sv
rtl/framebuffer_rect_blitter.sv
test/tb_framebuffer_rect_blitter.sv
